[rtl/gdad_pkg.sv]
// Shared types, codes and the month-length table for the date adder.
package gdad_pkg;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_STEP  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB   = 5'd28;
   localparam logic [4:0] DAYS_NONE  = 5'd0;

   typedef struct packed {
      logic load;
      logic check;
      logic step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic leap_ok;
      logic date_ok;
      logic count_zero;
      logic out_free;
   } sts_type;

   // zero for a month code that means nothing
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAYS_SHORT;
         MONTH_FEB:                                  len = leap ? DAYS_LEAP : DAYS_FEB;
         default:                                    len = DAYS_NONE;
      endcase
      return len;
   endfunction

endpackage

[rtl/gdad_leap.sv]
// Two-stage Gregorian leap-year unit, tagged with the year it was worked out for.
module gdad_leap (
   input  logic        clock,
   input  logic        reset,
   input  logic [13:0] year,
   output logic        leap,
   output logic [13:0] leap_year_tag
);

   // year / 100 = (year * 5243) >> 19, exact below 43690
   localparam logic [26:0] RECIP    = 27'd5243;
   localparam int          SHIFT    = 19;
   localparam logic [13:0] HUNDRED  = 14'd100;

   logic [26:0] prod;
   logic [7:0]  q_in,  q_ff;
   logic [13:0] yq_in, yq_ff;
   logic [13:0] hundreds;
   logic        leap_in, leap_ff;
   logic [13:0] yl_in, yl_ff;

   assign prod  = 27'(year) * RECIP;
   assign q_in  = prod[SHIFT +: 8];
   assign yq_in = year;

   assign hundreds = 14'(q_ff) * HUNDRED;
   assign leap_in  = (yq_ff[1:0] == 2'b00) &&
                     ((yq_ff != hundreds) || (q_ff[1:0] == 2'b00));
   assign yl_in    = yq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff    <= '0;
         yq_ff   <= '0;
         leap_ff <= 1'b1;
         yl_ff   <= '0;
      end else begin
         q_ff    <= q_in;
         yq_ff   <= yq_in;
         leap_ff <= leap_in;
         yl_ff   <= yl_in;
      end
   end

   assign leap          = leap_ff;
   assign leap_year_tag = yl_ff;

endmodule

[rtl/gdad_datapath.sv]
// Date registers, month-at-a-time advance and the result register.
module gdad_datapath #(
   parameter int ADD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gdad_pkg::cmd_type       cmd,
   output gdad_pkg::sts_type       sts,
   input  logic [4:0]              req_start_day,
   input  logic [3:0]              req_start_month,
   input  logic [13:0]             req_start_year,
   input  logic [ADD_BITS-1:0]     req_days_to_add,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [4:0]              rsp_result_day,
   output logic [3:0]              rsp_result_month,
   output logic [13:0]             rsp_result_year,
   output logic                    rsp_input_valid
);

   localparam int EW = ADD_BITS + 5;

   logic [4:0]          day_ff,   day_in;
   logic [3:0]          month_ff, month_in;
   logic [13:0]         year_ff,  year_in;
   logic [ADD_BITS-1:0] left_ff,  left_in;
   logic                valid_ff, valid_in;

   logic [4:0]          out_day_ff,   out_day_in;
   logic [3:0]          out_month_ff, out_month_in;
   logic [13:0]         out_year_ff,  out_year_in;
   logic                out_ok_ff,    out_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                leap;
   logic [13:0]         leap_tag;
   logic [4:0]          len;
   logic [4:0]          room;
   logic [EW-1:0]       left_ext;
   logic [EW-1:0]       room_ext;
   logic                fits;

   gdad_leap u_leap (
      .clock         (clock),
      .reset         (reset),
      .year          (year_ff),
      .leap          (leap),
      .leap_year_tag (leap_tag)
   );

   assign len      = gdad_pkg::month_len(month_ff, leap);
   assign room     = len - day_ff;
   assign left_ext = EW'(left_ff);
   assign room_ext = EW'(room);
   assign fits     = left_ext <= room_ext;

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      left_in  = left_ff;
      valid_in = valid_ff;
      if (cmd.load) begin
         day_in   = req_start_day;
         month_in = req_start_month;
         year_in  = req_start_year;
         left_in  = req_days_to_add;
         valid_in = 1'b0;
      end else if (cmd.check) begin
         valid_in = (month_ff >= gdad_pkg::MONTH_JAN) && (month_ff <= gdad_pkg::MONTH_DEC) &&
                    (day_ff != 5'd0) && (day_ff <= len);
      end else if (cmd.step) begin
         if (fits) begin
            day_in  = day_ff + left_ext[4:0];
            left_in = '0;
         end else begin
            left_in = ADD_BITS'(left_ext - room_ext - EW'(1));
            day_in  = 5'd1;
            if (month_ff == gdad_pkg::MONTH_DEC) begin
               month_in = gdad_pkg::MONTH_JAN;
               year_in  = year_ff + 14'd1;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end
      end
   end

   always_comb begin
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      out_ok_in    = out_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish) begin
         out_day_in   = day_ff;
         out_month_in = month_ff;
         out_year_in  = year_ff;
         out_ok_in    = valid_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      left_ff      <= left_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
      out_ok_ff    <= out_ok_in;
   end

   assign sts.leap_ok    = (leap_tag == year_ff);
   assign sts.date_ok    = valid_ff;
   assign sts.count_zero = (left_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_day   = out_day_ff;
   assign rsp_result_month = out_month_ff;
   assign rsp_result_year  = out_year_ff;
   assign rsp_input_valid  = out_ok_ff;

   a_step_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> day_ff != 5'd0)
      else $error("day zero after step");

   a_valid_month_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (month_ff >= gdad_pkg::MONTH_JAN) && (month_ff <= gdad_pkg::MONTH_DEC))
      else $error("month out of range on valid date");

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published item not shown");

endmodule

[rtl/gdad_ctrl.sv]
// Sequencer: load, check, month steps, hand-off to the result register.
module gdad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output gdad_pkg::cmd_type cmd,
   input  gdad_pkg::sts_type sts
);

   gdad_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         gdad_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = gdad_pkg::ST_CHECK;
            end
         end
         gdad_pkg::ST_CHECK: begin
            if (sts.leap_ok) begin
               cmd.check = 1'b1;
               state_in  = gdad_pkg::ST_STEP;
            end
         end
         gdad_pkg::ST_STEP: begin
            if (!sts.date_ok || sts.count_zero) begin
               state_in = gdad_pkg::ST_DONE;
            end else if (sts.leap_ok) begin
               cmd.step = 1'b1;
            end
         end
         gdad_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = gdad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gdad_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdad_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != gdad_pkg::ST_IDLE);

   a_cmd_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.check, cmd.step, cmd.publish}))
      else $error("more than one command");

   a_step_guard: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> sts.leap_ok && sts.date_ok && !sts.count_zero)
      else $error("step without a ready leap flag or work left");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> sts.out_free)
      else $error("publish into a full result register");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == gdad_pkg::ST_CHECK)
      else $error("accepted item not checked");

endmodule

[rtl/gregorian_date_add_days.sv]
// Top level: Gregorian date plus a day count.
//
//  channel | direction | handshake            | fields
//  req     | in        | req_valid/req_stall  | start_day, start_month, start_year, days_to_add
//  rsp     | out       | rsp_valid/rsp_stall  | result_day, result_month, result_year, input_valid
//
//  One item at a time: req_stall is high from accept until the result is handed to the result
//  register, and the next accept waits for the idle state. The datapath advances one month per
//  cycle while the leap flag matches its year; steps wait for the leap-year unit's registered
//  stages to catch up with each new year, at the check too when the year differs from the previous item's.
//  Synchronous active-high reset clears the sequencer and the result valid.
//  A new item is taken while a finished result waits under rsp_stall; the next one waits.
module gregorian_date_add_days #(
   parameter int ADD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [4:0]          req_start_day,
   input  logic [3:0]          req_start_month,
   input  logic [13:0]         req_start_year,
   input  logic [ADD_BITS-1:0] req_days_to_add,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [4:0]          rsp_result_day,
   output logic [3:0]          rsp_result_month,
   output logic [13:0]         rsp_result_year,
   output logic                rsp_input_valid
);

   gdad_pkg::cmd_type cmd;
   gdad_pkg::sts_type sts;

   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   gdad_datapath #(
      .ADD_BITS (ADD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .req_days_to_add  (req_days_to_add),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_input_valid  (rsp_input_valid)
   );

endmodule
